// ===== rtl/esu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esu_pkg
// Shared types and constants of the JSON string unescape block: request and
// result structs, decoder state, error codes and the hex and UTF-8 helpers.
// ----------------------------------------------------------------------------
package esu_pkg;

    localparam int MAX_RESULTS = 4;

    // Result kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [3:0] ERR_UNCLOSED  = 4'd0;
    localparam logic [3:0] ERR_CONTROL   = 4'd1;
    localparam logic [3:0] ERR_CUT_ESC   = 4'd2;
    localparam logic [3:0] ERR_BAD_ESC   = 4'd3;
    localparam logic [3:0] ERR_SHORT_HEX = 4'd4;
    localparam logic [3:0] ERR_NON_HEX   = 4'd5;
    localparam logic [3:0] ERR_NO_LOW    = 4'd6;
    localparam logic [3:0] ERR_BAD_LOW   = 4'd7;
    localparam logic [3:0] ERR_LONE_LOW  = 4'd8;
    localparam logic [3:0] ERR_BAD_UTF8  = 4'd9;
    localparam logic [3:0] ERR_NONE      = 4'd0;

    // Characters
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CTL_BS       = 8'h08;
    localparam logic [7:0] CTL_FF       = 8'h0C;
    localparam logic [7:0] CTL_LF       = 8'h0A;
    localparam logic [7:0] CTL_CR       = 8'h0D;
    localparam logic [7:0] CTL_TAB      = 8'h09;

    // Surrogate ranges and plane offset
    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;
    localparam logic [20:0] PLANE1     = 21'h10000;

    // Lead byte classes of the UTF-8 check
    localparam logic [2:0] LC_ANY = 3'd0;
    localparam logic [2:0] LC_E0  = 3'd1;
    localparam logic [2:0] LC_ED  = 3'd2;
    localparam logic [2:0] LC_F0  = 3'd3;
    localparam logic [2:0] LC_F4  = 3'd4;

    typedef enum logic [5:0] {
        MODE_PLAIN   = 6'b000001,
        MODE_ESC     = 6'b000010,
        MODE_HEX_HI  = 6'b000100,
        MODE_WANT_BS = 6'b001000,
        MODE_WANT_U  = 6'b010000,
        MODE_HEX_LO  = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } req_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] out_byte;
        logic [3:0] error_code;
        logic       last_of_run;
    } res_t;

    typedef struct packed {
        logic [1:0] need;
        logic [2:0] lead_class;
        logic       bad;
    } utf8_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] hex_value;
        logic [2:0]  hex_count;
        logic        hex_bad;
        logic [9:0]  high_part;
        utf8_t       utf8;
    } state_t;

    localparam state_t STATE_RESET = '{
        mode:      MODE_PLAIN,
        hex_value: 16'h0000,
        hex_count: 3'd0,
        hex_bad:   1'b0,
        high_part: 10'd0,
        utf8:      '{need: 2'd0, lead_class: LC_ANY, bad: 1'b0}
    };

    typedef struct packed {
        res_t [MAX_RESULTS-1:0] res;
        logic [2:0]             count;
    } bundle_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] digit;
    } hex_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } enc_t;

    // Decode one hex digit; non-hex gives ok low and digit zero
    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.digit = 4'd0;
        case (c) inside
            [8'h30:8'h39]: h.digit = c[3:0];
            [8'h61:8'h66],
            [8'h41:8'h46]: h.digit = 4'(c[2:0] + 3'd1) + 4'd8;
            default:       h.ok = 1'b0;
        endcase
        return h;
    endfunction

    // Encode a code point as one to four UTF-8 bytes, first byte in slot 0
    function automatic enc_t utf8_encode(input logic [20:0] cp);
        enc_t e;
        e.bytes = '0;
        if (cp < 21'h80) begin
            e.bytes[0] = cp[7:0];
            e.count    = 3'd1;
        end
        else if (cp < 21'h800) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.count    = 3'd2;
        end
        else if (cp < 21'h10000) begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.count    = 3'd3;
        end
        else begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.count    = 3'd4;
        end
        return e;
    endfunction

endpackage

// ===== rtl/json_string_unescape.sv =====
`timescale 1ns / 1ps
// A request is held in the request register, decoded, and its results enter
// the result register once free. Throughput: one request per cycle while each
// gives at most one result and the receiver does not stall; a request with
// several (up to four UTF-8 bytes) holds the result register, one out per cycle.
// Reset: asynchronous, active low; clears the decoder state and empties both
// the request and result registers, so the next byte starts a new string body.
// ----------------------------------------------------------------------------
// json_string_unescape
// Streaming JSON string body decoder: escapes to UTF-8, control and UTF-8
// checks, closing quote and numbered error results.
// ----------------------------------------------------------------------------
module json_string_unescape (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  esu_pkg::req_t   item,
    output logic            result_valid,
    input  logic            result_stall,
    output esu_pkg::res_t   result
);

    esu_pkg::req_t    req_reg;
    logic             full_reg;
    logic             full_next;
    esu_pkg::state_t  state_reg;
    esu_pkg::state_t  state_next;
    esu_pkg::bundle_t bundle;
    logic             load_ready;
    logic             advance;
    logic             accept;

    assign advance    = full_reg && load_ready;
    assign item_stall = full_reg && !load_ready;
    assign accept     = item_valid && !item_stall;

    // Request register occupancy
    always_comb
    begin
        full_next = full_reg;
        if (accept) begin
            full_next = 1'b1;
        end
        else if (advance) begin
            full_next = 1'b0;
        end
    end

    esu_decode u_decode (
        .cur    (state_reg),
        .req    (req_reg),
        .nxt    (state_next),
        .bundle (bundle)
    );

    esu_drain u_drain (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .bundle       (bundle),
        .load_ready   (load_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Control and decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            full_reg  <= 1'b0;
            state_reg <= esu_pkg::STATE_RESET;
        end
        else begin
            full_reg <= full_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Hold the accepted request
    always_ff @(posedge clk)
    begin
        if (accept) begin
            req_reg <= item;
        end
    end

endmodule

// ===== rtl/esu_utf8.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esu_utf8
// Strict UTF-8 tracker for plain bytes: follows the open sequence and
// latches a sticky bad flag on any malformed byte.
// ----------------------------------------------------------------------------
module esu_utf8 (
    input  esu_pkg::utf8_t cur,
    input  logic [7:0]     byte_in,
    output esu_pkg::utf8_t nxt
);

    logic [7:0] lo;
    logic [7:0] hi;

    // Pick the allowed range of the next continuation byte
    always_comb
    begin
        lo = 8'h80;
        hi = 8'hBF;
        case (cur.lead_class)
            esu_pkg::LC_E0: lo = 8'hA0;
            esu_pkg::LC_ED: hi = 8'h9F;
            esu_pkg::LC_F0: lo = 8'h90;
            esu_pkg::LC_F4: hi = 8'h8F;
            default:        ;
        endcase
    end

    // Advance the sequence state
    always_comb
    begin
        nxt = cur;
        if (!cur.bad) begin
            if (cur.need == 2'd0) begin
                case (byte_in) inside
                    [8'h00:8'h7F]: ;
                    [8'hC2:8'hDF]: nxt = '{need: 2'd1, lead_class: esu_pkg::LC_ANY, bad: 1'b0};
                    8'hE0:         nxt = '{need: 2'd2, lead_class: esu_pkg::LC_E0, bad: 1'b0};
                    8'hED:         nxt = '{need: 2'd2, lead_class: esu_pkg::LC_ED, bad: 1'b0};
                    [8'hE1:8'hEF]: nxt = '{need: 2'd2, lead_class: esu_pkg::LC_ANY, bad: 1'b0};
                    8'hF0:         nxt = '{need: 2'd3, lead_class: esu_pkg::LC_F0, bad: 1'b0};
                    [8'hF1:8'hF3]: nxt = '{need: 2'd3, lead_class: esu_pkg::LC_ANY, bad: 1'b0};
                    8'hF4:         nxt = '{need: 2'd3, lead_class: esu_pkg::LC_F4, bad: 1'b0};
                    default:       nxt.bad = 1'b1;
                endcase
            end
            else if (byte_in < lo || byte_in > hi) begin
                nxt = '{need: 2'd0, lead_class: esu_pkg::LC_ANY, bad: 1'b1};
            end
            else begin
                nxt.lead_class = esu_pkg::LC_ANY;
                nxt.need       = cur.need - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/esu_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esu_decode
// Single-pass decode of one request: next decoder state and the bundle of
// up to four results that the request causes.
// ----------------------------------------------------------------------------
module esu_decode (
    input  esu_pkg::state_t  cur,
    input  esu_pkg::req_t    req,
    output esu_pkg::state_t  nxt,
    output esu_pkg::bundle_t bundle
);

    esu_pkg::utf8_t  utf8_next;
    esu_pkg::hex_t   hex;
    esu_pkg::enc_t   enc;
    logic [15:0]     hex_value_next;
    logic [2:0]      hex_count_next;
    logic            hex_bad_next;
    logic            single_en;
    esu_pkg::res_t   single;
    logic            emit_en;
    logic [20:0]     cp;

    esu_utf8 u_utf8 (
        .cur     (cur.utf8),
        .byte_in (req.in_byte),
        .nxt     (utf8_next)
    );

    assign hex            = esu_pkg::hex_digit(req.in_byte);
    assign hex_value_next = {cur.hex_value[11:0], hex.digit};
    assign hex_count_next = cur.hex_count + 3'd1;
    assign hex_bad_next   = cur.hex_bad | ~hex.ok;
    assign enc            = esu_pkg::utf8_encode(cp);

    // Mode handling: state update and the single result or code point
    always_comb
    begin
        nxt       = cur;
        single_en = 1'b0;
        single    = '{result_kind: esu_pkg::KIND_BYTE, out_byte: 8'h00,
                      error_code: esu_pkg::ERR_NONE, last_of_run: 1'b0};
        emit_en   = 1'b0;
        cp        = 21'd0;

        case (cur.mode)
            esu_pkg::MODE_PLAIN:
            begin
                if (req.text_end) begin
                    single_en         = 1'b1;
                    single.result_kind = esu_pkg::KIND_ERROR;
                    single.error_code  = esu_pkg::ERR_UNCLOSED;
                    nxt               = esu_pkg::STATE_RESET;
                end
                else if (req.in_byte == esu_pkg::CH_QUOTE) begin
                    single_en = 1'b1;
                    if (cur.utf8.bad || cur.utf8.need != 2'd0) begin
                        single.result_kind = esu_pkg::KIND_ERROR;
                        single.error_code  = esu_pkg::ERR_BAD_UTF8;
                    end
                    else begin
                        single.result_kind = esu_pkg::KIND_CLOSED;
                    end
                    nxt = esu_pkg::STATE_RESET;
                end
                else if (req.in_byte < esu_pkg::CH_SPACE) begin
                    single_en          = 1'b1;
                    single.result_kind = esu_pkg::KIND_ERROR;
                    single.error_code  = esu_pkg::ERR_CONTROL;
                    nxt                = esu_pkg::STATE_RESET;
                end
                else if (req.in_byte == esu_pkg::CH_BACKSLASH) begin
                    nxt.mode = esu_pkg::MODE_ESC;
                end
                else begin
                    single_en       = 1'b1;
                    single.out_byte = req.in_byte;
                    nxt.utf8        = utf8_next;
                end
            end

            esu_pkg::MODE_ESC:
            begin
                single_en = 1'b1;
                nxt.mode  = esu_pkg::MODE_PLAIN;
                if (req.text_end) begin
                    single.result_kind = esu_pkg::KIND_ERROR;
                    single.error_code  = esu_pkg::ERR_CUT_ESC;
                    nxt                = esu_pkg::STATE_RESET;
                end
                else begin
                    case (req.in_byte) inside
                        esu_pkg::CH_QUOTE,
                        esu_pkg::CH_BACKSLASH,
                        esu_pkg::CH_SLASH: single.out_byte = req.in_byte;
                        esu_pkg::CH_B:     single.out_byte = esu_pkg::CTL_BS;
                        esu_pkg::CH_F:     single.out_byte = esu_pkg::CTL_FF;
                        esu_pkg::CH_N:     single.out_byte = esu_pkg::CTL_LF;
                        esu_pkg::CH_R:     single.out_byte = esu_pkg::CTL_CR;
                        esu_pkg::CH_T:     single.out_byte = esu_pkg::CTL_TAB;
                        esu_pkg::CH_U:
                        begin
                            single_en     = 1'b0;
                            nxt.mode      = esu_pkg::MODE_HEX_HI;
                            nxt.hex_value = 16'h0000;
                            nxt.hex_count = 3'd0;
                            nxt.hex_bad   = 1'b0;
                        end
                        default:
                        begin
                            single.result_kind = esu_pkg::KIND_ERROR;
                            single.error_code  = esu_pkg::ERR_BAD_ESC;
                            nxt                = esu_pkg::STATE_RESET;
                        end
                    endcase
                end
            end

            esu_pkg::MODE_HEX_HI,
            esu_pkg::MODE_HEX_LO:
            begin
                if (req.text_end) begin
                    single_en          = 1'b1;
                    single.result_kind = esu_pkg::KIND_ERROR;
                    single.error_code  = esu_pkg::ERR_SHORT_HEX;
                    nxt                = esu_pkg::STATE_RESET;
                end
                else begin
                    nxt.hex_value = hex_value_next;
                    nxt.hex_count = hex_count_next;
                    nxt.hex_bad   = hex_bad_next;
                    if (hex_count_next >= 3'd4) begin
                        if (hex_bad_next) begin
                            single_en          = 1'b1;
                            single.result_kind = esu_pkg::KIND_ERROR;
                            single.error_code  = esu_pkg::ERR_NON_HEX;
                            nxt                = esu_pkg::STATE_RESET;
                        end
                        else if (cur.mode == esu_pkg::MODE_HEX_HI) begin
                            case (hex_value_next) inside
                                [esu_pkg::HIGH_FIRST:esu_pkg::HIGH_LAST]:
                                begin
                                    nxt.high_part = hex_value_next[9:0];
                                    nxt.mode      = esu_pkg::MODE_WANT_BS;
                                end
                                [esu_pkg::LOW_FIRST:esu_pkg::LOW_LAST]:
                                begin
                                    single_en          = 1'b1;
                                    single.result_kind = esu_pkg::KIND_ERROR;
                                    single.error_code  = esu_pkg::ERR_LONE_LOW;
                                    nxt                = esu_pkg::STATE_RESET;
                                end
                                default:
                                begin
                                    emit_en  = 1'b1;
                                    cp       = {5'd0, hex_value_next};
                                    nxt.mode = esu_pkg::MODE_PLAIN;
                                end
                            endcase
                        end
                        else begin
                            case (hex_value_next) inside
                                [esu_pkg::LOW_FIRST:esu_pkg::LOW_LAST]:
                                begin
                                    emit_en  = 1'b1;
                                    cp       = esu_pkg::PLANE1
                                             + {1'b0, cur.high_part, hex_value_next[9:0]};
                                    nxt.mode = esu_pkg::MODE_PLAIN;
                                end
                                default:
                                begin
                                    single_en          = 1'b1;
                                    single.result_kind = esu_pkg::KIND_ERROR;
                                    single.error_code  = esu_pkg::ERR_BAD_LOW;
                                    nxt                = esu_pkg::STATE_RESET;
                                end
                            endcase
                        end
                    end
                end
            end

            esu_pkg::MODE_WANT_BS:
            begin
                if (req.text_end || req.in_byte != esu_pkg::CH_BACKSLASH) begin
                    single_en          = 1'b1;
                    single.result_kind = esu_pkg::KIND_ERROR;
                    single.error_code  = esu_pkg::ERR_NO_LOW;
                    nxt                = esu_pkg::STATE_RESET;
                end
                else begin
                    nxt.mode = esu_pkg::MODE_WANT_U;
                end
            end

            esu_pkg::MODE_WANT_U:
            begin
                if (req.text_end || req.in_byte != esu_pkg::CH_U) begin
                    single_en          = 1'b1;
                    single.result_kind = esu_pkg::KIND_ERROR;
                    single.error_code  = esu_pkg::ERR_NO_LOW;
                    nxt                = esu_pkg::STATE_RESET;
                end
                else begin
                    nxt.mode      = esu_pkg::MODE_HEX_LO;
                    nxt.hex_value = 16'h0000;
                    nxt.hex_count = 3'd0;
                    nxt.hex_bad   = 1'b0;
                end
            end

            default:
            begin
                nxt = esu_pkg::STATE_RESET;
            end
        endcase
    end

    // Assemble the result bundle and mark its last entry
    always_comb
    begin
        bundle.count = 3'd0;
        for (int i = 0; i < esu_pkg::MAX_RESULTS; i++) begin
            bundle.res[i] = '{result_kind: esu_pkg::KIND_BYTE, out_byte: enc.bytes[i],
                              error_code: esu_pkg::ERR_NONE, last_of_run: 1'b0};
        end
        if (emit_en) begin
            bundle.count = enc.count;
        end
        else if (single_en) begin
            bundle.res[0] = single;
            bundle.count  = 3'd1;
        end
        for (int i = 0; i < esu_pkg::MAX_RESULTS; i++) begin
            bundle.res[i].last_of_run = (bundle.count == 3'(i + 1));
        end
    end

endmodule

// ===== rtl/esu_drain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esu_drain
// Result register: holds one request's bundle and hands its results out one
// per cycle unless stalled; loads the next bundle when empty or as the last leaves.
// ----------------------------------------------------------------------------
module esu_drain (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  esu_pkg::bundle_t  bundle,
    output logic              load_ready,
    output logic              result_valid,
    input  logic              result_stall,
    output esu_pkg::res_t     result
);

    esu_pkg::res_t [esu_pkg::MAX_RESULTS-1:0] res_reg;
    logic [2:0] remain_reg;
    logic [2:0] remain_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       pop;

    assign result_valid = (remain_reg != 3'd0);
    assign result       = res_reg[idx_reg];
    assign pop          = result_valid && !result_stall;
    assign load_ready   = (remain_reg == 3'd0) || (remain_reg == 3'd1 && pop);

    // Advance the read position or take a new bundle
    always_comb
    begin
        remain_next = remain_reg;
        idx_next    = idx_reg;
        if (load) begin
            remain_next = bundle.count;
            idx_next    = 2'd0;
        end
        else if (pop) begin
            remain_next = remain_reg - 3'd1;
            idx_next    = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            remain_reg <= 3'd0;
            idx_reg    <= 2'd0;
        end
        else begin
            remain_reg <= remain_next;
            idx_reg    <= idx_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (load) begin
            res_reg <= bundle.res;
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: JSON string unescape testbench
// Streams string bodies through the decoder (a short directed set, then random
// well-formed strings with broken endings and noise), predicts every decoded
// byte, closing result and error in a scoreboard, and checks each result in
// order under several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module tb;

    import esu_pkg::*;

    localparam int PHASE_ITEMS    = 118;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;

    // Predicts the decoder and checks its results in order
    class unescape_checker;
        mode_t       mode;
        logic [15:0] hex_value;
        logic [2:0]  hex_count;
        logic        hex_bad;
        logic [9:0]  high_part;
        logic [1:0]  seq_need;
        logic [2:0]  seq_class;
        logic        seq_bad;
        res_t        unescaped_due[$];
        res_t        step_out[$];
        int          failures;

        function new();
            clear_state();
            failures = 0;
        endfunction

        function void clear_state();
            mode      = MODE_PLAIN;
            hex_value = 16'h0000;
            hex_count = 3'd0;
            hex_bad   = 1'b0;
            high_part = 10'd0;
            seq_need  = 2'd0;
            seq_class = LC_ANY;
            seq_bad   = 1'b0;
        endfunction

        // UTF-8 bytes of a code point, first byte in the top lane
        static function logic [31:0] encode_utf8(input logic [20:0] cp, output int count);
            logic [31:0] b;
            b = '0;
            if (cp < 21'h80) begin
                b[31:24] = cp[7:0];
                count    = 1;
            end
            else if (cp < 21'h800) begin
                b[31:24] = 8'hC0 | 8'(cp >> 6);
                b[23:16] = 8'h80 | 8'(cp & 21'h3F);
                count    = 2;
            end
            else if (cp < 21'h10000) begin
                b[31:24] = 8'hE0 | 8'(cp >> 12);
                b[23:16] = 8'h80 | 8'((cp >> 6) & 21'h3F);
                b[15:8]  = 8'h80 | 8'(cp & 21'h3F);
                count    = 3;
            end
            else begin
                b[31:24] = 8'hF0 | 8'((cp >> 18) & 21'h07);
                b[23:16] = 8'h80 | 8'((cp >> 12) & 21'h3F);
                b[15:8]  = 8'h80 | 8'((cp >> 6) & 21'h3F);
                b[7:0]   = 8'h80 | 8'(cp & 21'h3F);
                count    = 4;
            end
            return b;
        endfunction

        function void add_result(logic [1:0] kind, logic [7:0] b, logic [3:0] err);
            res_t r;
            if (step_out.size() >= MAX_RESULTS)
                return;
            r.result_kind = kind;
            r.out_byte    = b;
            r.error_code  = err;
            r.last_of_run = 1'b0;
            step_out.insert(step_out.size(), r);
        endfunction

        function void close_string(logic [1:0] kind, logic [3:0] err);
            add_result(kind, 8'h00, err);
            clear_state();
        endfunction

        function void add_code_point(logic [20:0] cp);
            logic [31:0] b;
            int          count;
            b = encode_utf8(cp, count);
            for (int i = 0; i < count; i++)
                add_result(KIND_BYTE, b[31-8*i -: 8], ERR_NONE);
        endfunction

        // Follow plain bytes as strict UTF-8; the verdict waits for the quote
        function void track_plain(logic [7:0] b);
            logic [7:0] lo;
            logic [7:0] hi;
            if (seq_bad)
                return;
            if (seq_need == 2'd0) begin
                if (b < 8'h80)
                    return;
                if (b >= 8'hC2 && b <= 8'hDF) begin
                    seq_need = 2'd1; seq_class = LC_ANY;
                end
                else if (b == 8'hE0) begin
                    seq_need = 2'd2; seq_class = LC_E0;
                end
                else if (b == 8'hED) begin
                    seq_need = 2'd2; seq_class = LC_ED;
                end
                else if (b >= 8'hE1 && b <= 8'hEF) begin
                    seq_need = 2'd2; seq_class = LC_ANY;
                end
                else if (b == 8'hF0) begin
                    seq_need = 2'd3; seq_class = LC_F0;
                end
                else if (b >= 8'hF1 && b <= 8'hF3) begin
                    seq_need = 2'd3; seq_class = LC_ANY;
                end
                else if (b == 8'hF4) begin
                    seq_need = 2'd3; seq_class = LC_F4;
                end
                else
                    seq_bad = 1'b1;
                return;
            end
            lo = 8'h80;
            hi = 8'hBF;
            case (seq_class)
                LC_E0:   lo = 8'hA0;
                LC_ED:   hi = 8'h9F;
                LC_F0:   lo = 8'h90;
                LC_F4:   hi = 8'h8F;
                default: ;
            endcase
            if (b < lo || b > hi) begin
                seq_bad   = 1'b1;
                seq_need  = 2'd0;
                seq_class = LC_ANY;
                return;
            end
            seq_class = LC_ANY;
            seq_need  = seq_need - 2'd1;
        endfunction

        function void start_hex(mode_t next);
            mode      = next;
            hex_value = 16'h0000;
            hex_count = 3'd0;
            hex_bad   = 1'b0;
        endfunction

        // All four digits are in: report, hold a high surrogate, or emit
        function void finish_hex();
            if (hex_bad) begin
                close_string(KIND_ERROR, ERR_NON_HEX);
                return;
            end
            if (mode == MODE_HEX_HI) begin
                if (hex_value >= HIGH_FIRST && hex_value <= HIGH_LAST) begin
                    high_part = hex_value[9:0];
                    mode      = MODE_WANT_BS;
                end
                else if (hex_value >= LOW_FIRST && hex_value <= LOW_LAST)
                    close_string(KIND_ERROR, ERR_LONE_LOW);
                else begin
                    add_code_point({5'd0, hex_value});
                    mode = MODE_PLAIN;
                end
            end
            else begin
                if (hex_value < LOW_FIRST || hex_value > LOW_LAST) begin
                    close_string(KIND_ERROR, ERR_BAD_LOW);
                    return;
                end
                add_code_point(PLANE1 + {1'b0, high_part, hex_value[9:0]});
                mode = MODE_PLAIN;
            end
        endfunction

        // Advance the decoder by one accepted request and queue its results
        function void decode_request(req_t r);
            logic [7:0] c;
            logic [3:0] digit;
            logic       is_hex;
            res_t       tail;
            c = r.in_byte;
            step_out.delete();
            case (mode)
                MODE_PLAIN: begin
                    if (r.text_end)
                        close_string(KIND_ERROR, ERR_UNCLOSED);
                    else if (c == CH_QUOTE) begin
                        if (seq_bad || seq_need != 2'd0)
                            close_string(KIND_ERROR, ERR_BAD_UTF8);
                        else
                            close_string(KIND_CLOSED, ERR_NONE);
                    end
                    else if (c < CH_SPACE)
                        close_string(KIND_ERROR, ERR_CONTROL);
                    else if (c == CH_BACKSLASH)
                        mode = MODE_ESC;
                    else begin
                        add_result(KIND_BYTE, c, ERR_NONE);
                        track_plain(c);
                    end
                end
                MODE_ESC: begin
                    if (r.text_end)
                        close_string(KIND_ERROR, ERR_CUT_ESC);
                    else begin
                        mode = MODE_PLAIN;
                        case (c)
                            CH_QUOTE, CH_BACKSLASH, CH_SLASH:
                                add_result(KIND_BYTE, c, ERR_NONE);
                            CH_B:    add_result(KIND_BYTE, CTL_BS, ERR_NONE);
                            CH_F:    add_result(KIND_BYTE, CTL_FF, ERR_NONE);
                            CH_N:    add_result(KIND_BYTE, CTL_LF, ERR_NONE);
                            CH_R:    add_result(KIND_BYTE, CTL_CR, ERR_NONE);
                            CH_T:    add_result(KIND_BYTE, CTL_TAB, ERR_NONE);
                            CH_U:    start_hex(MODE_HEX_HI);
                            default: close_string(KIND_ERROR, ERR_BAD_ESC);
                        endcase
                    end
                end
                MODE_HEX_HI, MODE_HEX_LO: begin
                    if (r.text_end)
                        close_string(KIND_ERROR, ERR_SHORT_HEX);
                    else begin
                        is_hex = 1'b1;
                        if (c >= 8'h30 && c <= 8'h39)
                            digit = c[3:0];
                        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
                            digit = 4'(c[2:0] + 4'd9);
                        else begin
                            digit  = 4'd0;
                            is_hex = 1'b0;
                        end
                        if (!is_hex)
                            hex_bad = 1'b1;
                        hex_value = {hex_value[11:0], digit};
                        hex_count = hex_count + 3'd1;
                        if (hex_count >= 3'd4)
                            finish_hex();
                    end
                end
                MODE_WANT_BS: begin
                    if (r.text_end || c != CH_BACKSLASH)
                        close_string(KIND_ERROR, ERR_NO_LOW);
                    else
                        mode = MODE_WANT_U;
                end
                MODE_WANT_U: begin
                    if (r.text_end || c != CH_U)
                        close_string(KIND_ERROR, ERR_NO_LOW);
                    else
                        start_hex(MODE_HEX_LO);
                end
                default: clear_state();
            endcase
            // Mark the last result of this request
            if (step_out.size() > 0) begin
                tail = step_out.pop_back();
                tail.last_of_run = 1'b1;
                step_out.insert(step_out.size(), tail);
            end
            foreach (step_out[i])
                unescaped_due.insert(unescaped_due.size(), step_out[i]);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (unescaped_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, ", $time,
                         "actual kind=%0d byte=%02h err=%0d last=%0b",
                         got.result_kind, got.out_byte, got.error_code, got.last_of_run);
                failures++;
                return;
            end
            want = unescaped_due.pop_front();
            if (got.result_kind !== want.result_kind || got.out_byte !== want.out_byte ||
                got.error_code !== want.error_code || got.last_of_run !== want.last_of_run) begin
                $display("%0t: mismatch, expected kind=%0d byte=%02h err=%0d last=%0b, ",
                         $time, want.result_kind, want.out_byte, want.error_code,
                         want.last_of_run,
                         "actual kind=%0d byte=%02h err=%0d last=%0b",
                         got.result_kind, got.out_byte, got.error_code, got.last_of_run);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    req_t item;
    logic result_valid;
    logic result_stall;
    res_t result;

    unescape_checker sb;
    req_t            string_body[$];
    int              sender_idle_pct;
    int              recv_stall_pct;
    int              holds_requested;

    json_string_unescape DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void push_byte(input logic [7:0] b);
        req_t r;
        r.in_byte  = b;
        r.text_end = 1'b0;
        string_body.insert(string_body.size(), r);
    endfunction

    // End of text; the byte lane carries junk
    function automatic void push_end();
        req_t r;
        r.in_byte  = 8'($urandom_range(255));
        r.text_end = 1'b1;
        string_body.insert(string_body.size(), r);
    endfunction

    // Backslash, 'u' and the leading digits of v; one digit may be made non-hex
    function automatic void push_hex(input logic [15:0] v, input int digits, input int bad_pos);
        logic [7:0] c;
        logic [3:0] n;
        push_byte(CH_BACKSLASH);
        push_byte(CH_U);
        for (int i = 0; i < digits; i++) begin
            n = v[15-4*i -: 4];
            if (i == bad_pos) begin
                if ($urandom_range(2) == 0)
                    c = CH_QUOTE;
                else begin
                    c = 8'($urandom_range(255));
                    if (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]})
                        c = 8'h67;
                end
            end
            else if (n < 4'd10)
                c = 8'h30 + 8'(n);
            else
                c = 8'(($urandom_range(1) ? 8'h41 : 8'h61) + n - 10);
            push_byte(c);
        end
    endfunction

    function automatic void push_simple_escape();
        push_byte(CH_BACKSLASH);
        case ($urandom_range(7))
            0:       push_byte(CH_QUOTE);
            1:       push_byte(CH_BACKSLASH);
            2:       push_byte(CH_SLASH);
            3:       push_byte(CH_B);
            4:       push_byte(CH_F);
            5:       push_byte(CH_N);
            6:       push_byte(CH_R);
            default: push_byte(CH_T);
        endcase
    endfunction

    // Valid plain UTF-8; an escape may fall inside a multibyte sequence
    function automatic void push_plain_utf8();
        logic [20:0] cp;
        logic [31:0] b;
        int          n;
        case ($urandom_range(7))
            1: cp = 21'($urandom_range(12'h7FF, 8'h80));
            2: begin
                cp = 21'($urandom_range(16'hFFFF, 12'h800));
                if (cp >= 21'hD800 && cp <= 21'hDFFF)
                    cp = cp ^ 21'h4000;
            end
            3: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
            4: begin
                case ($urandom_range(6))
                    0:       cp = 21'h80;
                    1:       cp = 21'h7FF;
                    2:       cp = 21'h800;
                    3:       cp = 21'hFFFF;
                    4:       cp = 21'h10000;
                    5:       cp = 21'h10FFFF;
                    default: cp = 21'hFFFD;
                endcase
            end
            default: begin
                cp = 21'($urandom_range(8'h7F, 8'h20));
                if (cp == 21'(CH_QUOTE) || cp == 21'(CH_BACKSLASH))
                    cp = 21'h41;
            end
        endcase
        b = unescape_checker::encode_utf8(cp, n);
        for (int i = 0; i < n; i++) begin
            push_byte(b[31-8*i -: 8]);
            if (i == 0 && n > 1 && $urandom_range(3) == 0)
                push_simple_escape();
        end
    endfunction

    // Malformed plain UTF-8: stray, overlong, surrogate, out of range, cut
    function automatic void push_bad_utf8();
        case ($urandom_range(7))
            0: push_byte(8'($urandom_range(8'hBF, 8'h80)));
            1: begin
                push_byte(8'($urandom_range(8'hC1, 8'hC0)));
                push_byte(8'($urandom_range(8'hBF, 8'h80)));
            end
            2: push_byte(8'($urandom_range(8'hFF, 8'hF5)));
            3: begin
                push_byte(8'hE0);
                push_byte(8'($urandom_range(8'h9F, 8'h80)));
                push_byte(8'($urandom_range(8'hBF, 8'h80)));
            end
            4: begin
                push_byte(8'hED);
                push_byte(8'($urandom_range(8'hBF, 8'hA0)));
                push_byte(8'($urandom_range(8'hBF, 8'h80)));
            end
            5: begin
                push_byte(8'hF0);
                push_byte(8'($urandom_range(8'h8F, 8'h80)));
                push_byte(8'($urandom_range(8'hBF, 8'h80)));
                push_byte(8'($urandom_range(8'hBF, 8'h80)));
            end
            6: begin
                push_byte(8'hF4);
                push_byte(8'($urandom_range(8'hBF, 8'h90)));
                push_byte(8'($urandom_range(8'hBF, 8'h80)));
                push_byte(8'($urandom_range(8'hBF, 8'h80)));
            end
            default: push_byte(8'($urandom_range(8'hF4, 8'hC2)));
        endcase
    endfunction

    // One string body: mostly well formed and closed, some broken, some noise
    function automatic void push_random_string();
        logic [15:0] v;
        logic [7:0]  c;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(4, 1)) begin
                if ($urandom_range(5) == 0)
                    push_end();
                else
                    push_byte(8'($urandom_range(255)));
            end
            return;
        end
        repeat ($urandom_range(5)) begin
            case ($urandom_range(9))
                0, 1, 2: push_plain_utf8();
                3:       push_bad_utf8();
                4, 5:    push_simple_escape();
                6, 7: begin
                    v = 16'($urandom);
                    if (v[15:11] == 5'b11011)
                        v = v ^ 16'h4000;
                    push_hex(v, 4, -1);
                end
                default: begin
                    push_hex(16'($urandom_range(HIGH_LAST, HIGH_FIRST)), 4, -1);
                    push_hex(16'($urandom_range(LOW_LAST, LOW_FIRST)), 4, -1);
                end
            endcase
        end
        if ($urandom_range(3) != 0) begin
            push_byte(CH_QUOTE);
            return;
        end
        // Broken endings
        case ($urandom_range(10))
            0: push_byte(8'($urandom_range(8'h1F, 8'h00)));
            1: push_end();
            2: begin
                push_byte(CH_BACKSLASH);
                push_end();
            end
            3: begin
                push_byte(CH_BACKSLASH);
                c = 8'($urandom_range(255));
                if (c inside {CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R,
                              CH_T, CH_U})
                    c = 8'h78;
                push_byte(c);
            end
            4: begin
                push_hex(16'($urandom), $urandom_range(3),
                         $urandom_range(1) ? int'($urandom_range(2)) : -1);
                push_end();
            end
            5: push_hex(16'($urandom), 4, $urandom_range(3));
            6: push_hex(16'($urandom_range(LOW_LAST, LOW_FIRST)), 4, -1);
            7: begin
                push_hex(16'($urandom_range(HIGH_LAST, HIGH_FIRST)), 4, -1);
                c = 8'($urandom_range(255));
                if (c == CH_BACKSLASH)
                    c = 8'h41;
                if ($urandom_range(3) == 0)
                    push_end();
                else
                    push_byte(c);
            end
            8: begin
                push_hex(16'($urandom_range(HIGH_LAST, HIGH_FIRST)), 4, -1);
                push_byte(CH_BACKSLASH);
                c = 8'($urandom_range(255));
                if (c == CH_U)
                    c = 8'h41;
                if ($urandom_range(3) == 0)
                    push_end();
                else
                    push_byte(c);
            end
            9: begin
                push_hex(16'($urandom_range(HIGH_LAST, HIGH_FIRST)), 4, -1);
                v = 16'($urandom);
                if (v >= LOW_FIRST && v <= LOW_LAST)
                    v = v ^ 16'h4000;
                push_hex(v, 4, -1);
            end
            default: begin
                push_hex(16'($urandom_range(HIGH_LAST, HIGH_FIRST)), 4, -1);
                push_hex(16'($urandom_range(LOW_LAST, LOW_FIRST)), $urandom_range(3), -1);
                push_end();
            end
        endcase
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_request(input req_t r);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= r;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.decode_request(r);
    endtask

    task automatic send_body();
        foreach (string_body[i])
            send_request(string_body[i]);
        string_body.delete();
    endtask

    // Receiver: random stall, or a long hold when one is requested
    initial begin
        int holds_served;
        int hold_left;
        holds_served = 0;
        hold_left    = 0;
        result_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left == 0 && holds_served < holds_requested) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
                result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Check each accepted result
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                sb.check_result(result);
        end
    end

    // Drop the run when nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: timeout, nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int sent;
        sb              = new();
        rst_n           = 1'b0;
        item_valid      = 1'b0;
        item            = '0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        holds_requested = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: control bytes, bad plain UTF-8, escapes, cut text, a pair
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CH_QUOTE);
        push_byte(CH_BACKSLASH);
        push_byte(CH_T);
        push_byte(CH_QUOTE);
        push_byte(CH_BACKSLASH);
        push_byte(8'h78);
        push_byte(CH_BACKSLASH);
        push_end();
        push_byte(8'h1F);
        push_byte(8'h7F);
        push_end();
        push_hex(16'hD800, 4, -1);
        push_hex(16'hDC00, 4, -1);
        push_byte(CH_QUOTE);
        send_body();

        // Random phases with different idle and stall mixes
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    sender_idle_pct = 0;  recv_stall_pct = 0;
                    holds_requested++;
                end
                1: begin sender_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin sender_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                push_random_string();
                sent += string_body.size();
                send_body();
            end
        end

        @(negedge clk);
        item_valid     <= 1'b0;
        recv_stall_pct = 0;
        while (sb.unescaped_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
